### rtl/bmm_pkg.sv
// Shared types and constants for the binary matrix multiplier.
`timescale 1ns / 1ps

package bmm_pkg;

    localparam int ROW_W   = 6;   // row and column number width
    localparam int BITS_W  = 64;  // width of one stored matrix row
    localparam int SIZE_W  = 7;   // matrix size register width
    localparam int COUNT_W = 7;   // product count width

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // Request type codes.
    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ROW_W-1:0]  row_index;
        logic [BITS_W-1:0] row_bits;
    } req_t;

    typedef struct packed {
        logic [ROW_W-1:0]   out_row;
        logic [ROW_W-1:0]   out_col;
        logic [COUNT_W-1:0] product_count;
        logic               last_of_row;
    } res_t;

    // Control from the sequencer to the column counters.
    typedef struct packed {
        logic clear;
        logic acc_en;
        logic a_bit;
    } lane_ctl_t;

endpackage

### rtl/binary_matrix_multiply.sv
// Top level of the binary matrix multiplier: sequencer, row stores and result register.
`timescale 1ns / 1ps

// Throughput: busy stays low for a load item, so loads can be issued every cycle. A compute
// item of size N holds busy while the sequencer walks the B store one row per cycle through
// its single read port, then emits one column per cycle from the counters into the result
// register. The next item can be accepted in the cycle that carries the last result. The
// receiver cannot stall. Reset (rst_n, asynchronous, active low) clears the sequencer and sets
// the size to 64; the row stores are not cleared and hold undefined contents until written.

module binary_matrix_multiply #(
    parameter int MAX_SIZE = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Item channel.
    input  logic                          start,
    output logic                          busy,
    input  bmm_pkg::req_t                 in_item,
    // Result channel.
    output logic                          result_valid,
    output bmm_pkg::res_t                 result,
    // Size register write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bmm_pkg::SIZE_W-1:0]    cfg_data
);

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam logic [bmm_pkg::SIZE_W-1:0] MAX_SIZE_V = bmm_pkg::SIZE_W'(MAX_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ACCUM = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    logic [bmm_pkg::SIZE_W-1:0]   size_cfg_reg;
    logic [bmm_pkg::SIZE_W-1:0]   size_reg, size_next;
    logic [bmm_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [AW-1:0]                k_reg, k_next;
    logic [AW-1:0]                j_reg, j_next;
    logic                         out_valid_reg, out_valid_next;
    bmm_pkg::res_t                out_reg, out_next;

    logic [bmm_pkg::SIZE_W-1:0]   eff_size;
    logic [bmm_pkg::SIZE_W-1:0]   row_ext;
    logic                         accept;
    logic                         do_load_a, do_load_b, do_compute;
    logic [AW-1:0]                wr_addr;
    logic [bmm_pkg::SIZE_W-1:0]   k_succ, j_succ;
    logic                         k_last, j_last;
    logic                         a_re, b_re;
    logic [AW-1:0]                b_raddr;
    logic [bmm_pkg::BITS_W-1:0]   a_rdata, b_rdata;
    logic [bmm_pkg::ROW_W-1:0]    k_col;
    bmm_pkg::lane_ctl_t           lane_ctl;
    logic [bmm_pkg::COUNT_W-1:0]  lane_count;

    // The register may hold more than the stores can take; clip it here.
    assign eff_size = (size_cfg_reg > MAX_SIZE_V) ? MAX_SIZE_V : size_cfg_reg;
    assign row_ext  = bmm_pkg::SIZE_W'(in_item.row_index);
    assign accept   = start && !busy;
    assign wr_addr  = AW'(in_item.row_index);

    // Loads beyond the store depth and computes beyond the size in use are dropped.
    // A request type of three matches none of these and is dropped as well.
    assign do_load_a  = accept && (in_item.req_type == bmm_pkg::REQ_LOAD_A)
                        && (row_ext < MAX_SIZE_V);
    assign do_load_b  = accept && (in_item.req_type == bmm_pkg::REQ_LOAD_B)
                        && (row_ext < MAX_SIZE_V);
    assign do_compute = accept && (in_item.req_type == bmm_pkg::REQ_COMPUTE)
                        && (eff_size != '0) && (row_ext < eff_size);

    assign k_succ = bmm_pkg::SIZE_W'(k_reg) + bmm_pkg::SIZE_W'(1);
    assign j_succ = bmm_pkg::SIZE_W'(j_reg) + bmm_pkg::SIZE_W'(1);
    assign k_last = (k_succ == size_reg);
    assign j_last = (j_succ == size_reg);

    // A[i] and B[0] are read together at acceptance; the A read data then holds
    // while B rows stream in, one per cycle.
    assign a_re    = do_compute;
    assign b_re    = do_compute || ((state_reg == ST_ACCUM) && !k_last);
    assign b_raddr = do_compute ? '0 : AW'(k_succ);

    bmm_ram #(
        .WIDTH (bmm_pkg::BITS_W),
        .DEPTH (MAX_SIZE)
    ) u_a_store (
        .clk   (clk),
        .we    (do_load_a),
        .waddr (wr_addr),
        .wdata (in_item.row_bits),
        .re    (a_re),
        .raddr (wr_addr),
        .rdata (a_rdata)
    );

    bmm_ram #(
        .WIDTH (bmm_pkg::BITS_W),
        .DEPTH (MAX_SIZE)
    ) u_b_store (
        .clk   (clk),
        .we    (do_load_b),
        .waddr (wr_addr),
        .wdata (in_item.row_bits),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Each accumulate cycle adds row B[k] into the counters, gated by A[i][k].
    assign k_col          = bmm_pkg::ROW_W'(k_reg);
    assign lane_ctl.clear  = do_compute;
    assign lane_ctl.acc_en = (state_reg == ST_ACCUM);
    assign lane_ctl.a_bit  = a_rdata[k_col];

    bmm_lanes #(
        .MAX_SIZE (MAX_SIZE)
    ) u_lanes (
        .clk   (clk),
        .ctl   (lane_ctl),
        .b_row (b_rdata),
        .sel   (j_reg),
        .count (lane_count)
    );

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (do_compute)
                begin
                    state_next = ST_ACCUM;
                    size_next  = eff_size;
                    row_next   = in_item.row_index;
                    k_next     = '0;
                end
            end
            ST_ACCUM:
            begin
                k_next = AW'(k_succ);
                if (k_last)
                begin
                    state_next = ST_EMIT;
                    j_next     = '0;
                end
            end
            ST_EMIT:
            begin
                out_valid_next        = 1'b1;
                out_next.out_row       = row_reg;
                out_next.out_col       = bmm_pkg::ROW_W'(j_reg);
                out_next.product_count = lane_count;
                out_next.last_of_row   = j_last;
                j_next                = AW'(j_succ);
                if (j_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            size_cfg_reg  <= bmm_pkg::SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        row_reg  <= row_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        out_reg  <= out_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### rtl/bmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module bmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bmm_lanes.sv
// Column counters: one count per product column, accumulated one k per cycle while enabled.
`timescale 1ns / 1ps

module bmm_lanes #(
    parameter int MAX_SIZE = 64
) (
    input  logic                                               clk,
    input  bmm_pkg::lane_ctl_t                                 ctl,
    input  logic [bmm_pkg::BITS_W-1:0]                         b_row,
    input  logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] sel,
    output logic [bmm_pkg::COUNT_W-1:0]                        count
);

    logic [bmm_pkg::COUNT_W-1:0] count_reg [MAX_SIZE];

    // Each column adds one when both A[i][k] and B[k][j] are set.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_SIZE; j++)
        begin
            if (ctl.clear)
            begin
                count_reg[j] <= '0;
            end
            else if (ctl.acc_en)
            begin
                count_reg[j] <= count_reg[j]
                    + bmm_pkg::COUNT_W'(ctl.a_bit & b_row[j]);
            end
        end
    end

    assign count = count_reg[sel];

endmodule
